// File: rtl/bgi_pkg.sv
// shared constants, codes and command/status types for the bilinear grid interpolator
package bgi_pkg;

  localparam int MAX_ROWS  = 16;
  localparam int MAX_COLS  = 16;
  localparam int FRAC_BITS = 16;

  localparam int DATA_W = 32;
  localparam int CFG_W  = 5;
  localparam int REQ_W  = 2;
  localparam int STAT_W = 2;
  localparam int ROW_W  = $clog2(MAX_ROWS);
  localparam int COL_W  = $clog2(MAX_COLS);
  localparam int IDX_W  = (ROW_W > COL_W) ? ROW_W : COL_W;
  localparam int GRID_AW = ROW_W + COL_W;
  localparam int U_W    = FRAC_BITS;
  localparam int W_W    = FRAC_BITS + 1;
  localparam int R_W    = DATA_W + FRAC_BITS + 1;
  localparam int F_W    = R_W + W_W;
  localparam int CNT_W  = $clog2(FRAC_BITS);

  localparam logic [REQ_W-1:0] REQ_AX1   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_AX2   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_GRID  = 2'd2;
  localparam logic [REQ_W-1:0] REQ_QUERY = 2'd3;

  localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STAT_AX1_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] STAT_AX2_EMPTY = 2'd2;

  localparam logic [0:0] CFG_ROWS = 1'd0;
  localparam logic [0:0] CFG_COLS = 1'd1;

  typedef enum logic [1:0] {RD_FIRST = 2'd0, RD_LAST = 2'd1, RD_ONE = 2'd2,
                            RD_KNEXT = 2'd3} rd_sel_t;
  typedef enum logic [1:0] {LOC_NONE = 2'd0, LOC_ZERO = 2'd1, LOC_LAST = 2'd2,
                            LOC_SEG = 2'd3} loc_op_t;
  typedef enum logic [1:0] {MA_GRID = 2'd0, MA_R0 = 2'd1, MA_R1 = 2'd2} mul_a_t;
  typedef enum logic [1:0] {MB_INV2 = 2'd0, MB_U2 = 2'd1, MB_INV1 = 2'd2,
                            MB_U1 = 2'd3} mul_b_t;
  typedef enum logic [2:0] {ACC_NONE = 3'd0, ACC_R0_LOAD = 3'd1, ACC_R0_ADD = 3'd2,
                            ACC_R1_LOAD = 3'd3, ACC_R1_ADD = 3'd4, ACC_F_LOAD = 3'd5,
                            ACC_F_ADD = 3'd6} acc_op_t;
  typedef enum logic [1:0] {OUT_NONE = 2'd0, OUT_EMPTY = 2'd1, OUT_OK = 2'd2} out_sel_t;

  typedef struct packed {
    logic     write;
    logic     load;
    logic     axis;
    rd_sel_t  rd_sel;
    loc_op_t  loc;
    logic     save_prev;
    logic     k_init;
    logic     k_inc;
    logic     div_step;
    logic     row_hi;
    logic     col_hi;
    mul_a_t   mul_a;
    mul_b_t   mul_b;
    acc_op_t  acc;
    out_sel_t out_sel;
  } bgi_cmd_t;

  typedef struct packed {
    logic n1_zero;
    logic n2_zero;
    logic n_small;
    logic x_le;
    logic x_ge;
    logic k_last;
  } bgi_stat_t;

endpackage

// File: rtl/bilinear_grid_interp.sv
// Bilinear grid interpolator: a request is taken when start is high and busy is low. Write
// requests (breakpoints, grid values) give no result; busy stays low. In a query, each
// axis is searched one breakpoint per cycle through a registered store read, its fraction
// (when it lies inside a segment) comes from a restoring divider giving one bit per cycle,
// and the four corners are blended through one shared multiplier. The result appears for
// exactly one cycle with done high and cannot be held off. An empty axis gives a status
// code instead, registered through the empty state of the controller.
module bilinear_grid_interp (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [bgi_pkg::REQ_W-1:0]     req_type,
  input  logic [3:0]                    row_index,
  input  logic [3:0]                    col_index,
  input  logic signed [31:0]            write_data,
  input  logic signed [31:0]            query_x1,
  input  logic signed [31:0]            query_x2,
  input  logic                          cfg_write,
  input  logic [0:0]                    cfg_index,
  input  logic [bgi_pkg::CFG_W-1:0]     cfg_data,
  output logic                          done,
  output logic signed [31:0]            interp_value,
  output logic [bgi_pkg::STAT_W-1:0]    status
);
  import bgi_pkg::*;

  bgi_cmd_t cmd;
  bgi_stat_t stat;

  bgi_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .req_type (req_type),
    .stat     (stat),
    .cmd      (cmd),
    .busy     (busy),
    .done     (done)
  );

  bgi_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .req_type     (req_type),
    .row_index    (row_index),
    .col_index    (col_index),
    .write_data   (write_data),
    .query_x1     (query_x1),
    .query_x2     (query_x2),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .interp_value (interp_value),
    .status       (status)
  );

endmodule

// File: rtl/bgi_datapath.sv
// datapath: breakpoint and grid stores, segment search compares, divider and blend multiplier
module bgi_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  bgi_pkg::bgi_cmd_t             cmd,
  output bgi_pkg::bgi_stat_t            stat,
  input  logic [bgi_pkg::REQ_W-1:0]     req_type,
  input  logic [3:0]                    row_index,
  input  logic [3:0]                    col_index,
  input  logic signed [31:0]            write_data,
  input  logic signed [31:0]            query_x1,
  input  logic signed [31:0]            query_x2,
  input  logic                          cfg_write,
  input  logic [0:0]                    cfg_index,
  input  logic [bgi_pkg::CFG_W-1:0]     cfg_data,
  output logic signed [31:0]            interp_value,
  output logic [bgi_pkg::STAT_W-1:0]    status
);
  import bgi_pkg::*;

  logic [CFG_W-1:0] rows_in_use;
  logic [CFG_W-1:0] cols_in_use;
  logic [CFG_W-1:0] n1, n2, n_cur, n_m1;

  logic signed [DATA_W-1:0] axis1_mem [MAX_ROWS];
  logic signed [DATA_W-1:0] axis2_mem [MAX_COLS];
  logic signed [DATA_W-1:0] grid_mem [MAX_ROWS*MAX_COLS];

  logic signed [DATA_W-1:0] qx1, qx2, x_cur, ax_q, prev, g_q;
  logic [IDX_W-1:0] k, rd_addr;
  logic [ROW_W-1:0] i0, i1;
  logic [COL_W-1:0] j0, j1;
  logic [U_W-1:0] u1, u2;
  logic [DATA_W-1:0] rem, den;
  logic [DATA_W:0] rem2;
  logic [DATA_W:0] rem_sub;
  logic q_bit;
  logic [GRID_AW-1:0] g_addr;
  logic signed [R_W-1:0] mul_a, acc_r0, acc_r1;
  logic [W_W-1:0] mul_b;
  logic signed [F_W:0] mul_full;
  logic signed [F_W-1:0] prod, acc_f;
  logic signed [DATA_W:0] seg_num, seg_den;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use <= CFG_W'(1);
      cols_in_use <= CFG_W'(1);
    end else if (cfg_write) begin
      if (cfg_index == CFG_ROWS) rows_in_use <= cfg_data;
      else cols_in_use <= cfg_data;
    end
  end

  // sizes above the store depth act as the depth
  assign n1 = (rows_in_use > CFG_W'(MAX_ROWS)) ? CFG_W'(MAX_ROWS) : rows_in_use;
  assign n2 = (cols_in_use > CFG_W'(MAX_COLS)) ? CFG_W'(MAX_COLS) : cols_in_use;
  assign n_cur = cmd.axis ? n2 : n1;
  assign n_m1 = n_cur - CFG_W'(1);
  assign x_cur = cmd.axis ? qx2 : qx1;

  assign stat.n1_zero = (n1 == '0);
  assign stat.n2_zero = (n2 == '0);
  assign stat.n_small = (n_cur <= CFG_W'(1));
  assign stat.x_le = (x_cur <= ax_q);
  assign stat.x_ge = (x_cur >= ax_q);
  assign stat.k_last = (CFG_W'(k) == n_m1);

  always_comb begin
    case (cmd.rd_sel)
      RD_FIRST: rd_addr = '0;
      RD_LAST:  rd_addr = n_m1[IDX_W-1:0];
      RD_ONE:   rd_addr = IDX_W'(1);
      RD_KNEXT: rd_addr = k + IDX_W'(1);
      default:  rd_addr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.write && req_type == REQ_AX1) axis1_mem[row_index[ROW_W-1:0]] <= write_data;
    if (cmd.write && req_type == REQ_AX2) axis2_mem[col_index[COL_W-1:0]] <= write_data;
    if (cmd.write && req_type == REQ_GRID)
      grid_mem[{row_index[ROW_W-1:0], col_index[COL_W-1:0]}] <= write_data;
    ax_q <= cmd.axis ? axis2_mem[rd_addr[COL_W-1:0]] : axis1_mem[rd_addr[ROW_W-1:0]];
    g_q <= grid_mem[g_addr];
  end

  assign g_addr = {cmd.row_hi ? i1 : i0, cmd.col_hi ? j1 : j0};

  assign seg_num = {x_cur[DATA_W-1], x_cur} - {prev[DATA_W-1], prev};
  assign seg_den = {ax_q[DATA_W-1], ax_q} - {prev[DATA_W-1], prev};

  // restoring division, one quotient bit per step
  assign rem2 = {rem, 1'b0};
  assign rem_sub = rem2 - {1'b0, den};
  assign q_bit = (rem2 >= {1'b0, den});

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      qx1 <= query_x1;
      qx2 <= query_x2;
    end
    if (cmd.save_prev) prev <= ax_q;
    if (cmd.k_init) k <= IDX_W'(1);
    else if (cmd.k_inc) k <= k + IDX_W'(1);
    case (cmd.loc)
      LOC_ZERO: begin
        if (cmd.axis) begin
          j0 <= '0; j1 <= '0; u2 <= '0;
        end else begin
          i0 <= '0; i1 <= '0; u1 <= '0;
        end
      end
      LOC_LAST: begin
        if (cmd.axis) begin
          j0 <= n_m1[COL_W-1:0]; j1 <= n_m1[COL_W-1:0]; u2 <= '0;
        end else begin
          i0 <= n_m1[ROW_W-1:0]; i1 <= n_m1[ROW_W-1:0]; u1 <= '0;
        end
      end
      LOC_SEG: begin
        rem <= seg_num[DATA_W-1:0];
        den <= seg_den[DATA_W-1:0];
        if (cmd.axis) begin
          j0 <= COL_W'(k - IDX_W'(1)); j1 <= k[COL_W-1:0]; u2 <= '0;
        end else begin
          i0 <= ROW_W'(k - IDX_W'(1)); i1 <= k[ROW_W-1:0]; u1 <= '0;
        end
      end
      default: begin
      end
    endcase
    if (cmd.div_step) begin
      rem <= q_bit ? rem_sub[DATA_W-1:0] : rem2[DATA_W-1:0];
      if (cmd.axis) u2 <= {u2[U_W-2:0], q_bit};
      else u1 <= {u1[U_W-2:0], q_bit};
    end
  end

  // blend: one shared multiplier, registered product
  always_comb begin
    case (cmd.mul_a)
      MA_GRID: mul_a = R_W'(g_q);
      MA_R0:   mul_a = acc_r0;
      MA_R1:   mul_a = acc_r1;
      default: mul_a = acc_r0;
    endcase
    case (cmd.mul_b)
      MB_INV2: mul_b = (W_W'(1) << FRAC_BITS) - W_W'(u2);
      MB_U2:   mul_b = W_W'(u2);
      MB_INV1: mul_b = (W_W'(1) << FRAC_BITS) - W_W'(u1);
      MB_U1:   mul_b = W_W'(u1);
      default: mul_b = W_W'(u1);
    endcase
  end

  assign mul_full = mul_a * $signed({1'b0, mul_b});

  always_ff @(posedge clk) begin
    prod <= mul_full[F_W-1:0];
    case (cmd.acc)
      ACC_R0_LOAD: acc_r0 <= prod[R_W-1:0];
      ACC_R0_ADD:  acc_r0 <= acc_r0 + prod[R_W-1:0];
      ACC_R1_LOAD: acc_r1 <= prod[R_W-1:0];
      ACC_R1_ADD:  acc_r1 <= acc_r1 + prod[R_W-1:0];
      ACC_F_LOAD:  acc_f <= prod;
      ACC_F_ADD:   acc_f <= acc_f + prod;
      default: begin
      end
    endcase
  end

  // floor of the exact sum over 2^(2*frac) is its upper bits
  always_comb begin
    case (cmd.out_sel)
      OUT_OK: begin
        interp_value = acc_f[2*FRAC_BITS +: DATA_W];
        status = STAT_OK;
      end
      OUT_EMPTY: begin
        interp_value = '0;
        status = stat.n1_zero ? STAT_AX1_EMPTY : STAT_AX2_EMPTY;
      end
      default: begin
        interp_value = '0;
        status = STAT_OK;
      end
    endcase
  end

endmodule

// File: rtl/bgi_controller.sv
// controller: sequences the axis searches, fraction divisions and corner blend
module bgi_controller (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [bgi_pkg::REQ_W-1:0] req_type,
  input  bgi_pkg::bgi_stat_t        stat,
  output bgi_pkg::bgi_cmd_t         cmd,
  output logic                      busy,
  output logic                      done
);
  import bgi_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_EMPTY  = 9'b000000010,
    S_FIRST  = 9'b000000100,
    S_LAST   = 9'b000001000,
    S_CHK    = 9'b000010000,
    S_SCAN   = 9'b000100000,
    S_DIV    = 9'b001000000,
    S_BLEND  = 9'b010000000,
    S_DONE   = 9'b100000000
  } state_t;

  state_t state, state_next;
  logic axis, axis_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic axis_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      axis <= 1'b0;
      cnt <= '0;
    end else begin
      state <= state_next;
      axis <= axis_next;
      cnt <= cnt_next;
    end
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE) || (state == S_EMPTY);

  always_comb begin
    state_next = state;
    axis_next = axis;
    cnt_next = cnt;
    axis_end = 1'b0;
    cmd = '0;
    cmd.axis = axis;
    case (state)
      S_IDLE: begin
        if (start) begin
          if (req_type == REQ_QUERY) begin
            cmd.load = 1'b1;
            axis_next = 1'b0;
            if (stat.n1_zero || stat.n2_zero) state_next = S_EMPTY;
            else state_next = S_FIRST;
          end else begin
            cmd.write = 1'b1;
          end
        end
      end
      S_EMPTY: begin
        cmd.out_sel = OUT_EMPTY;
        state_next = S_IDLE;
      end
      S_FIRST: begin
        cmd.rd_sel = RD_FIRST;
        if (stat.n_small) begin
          cmd.loc = LOC_ZERO;
          axis_end = 1'b1;
        end else begin
          state_next = S_LAST;
        end
      end
      S_LAST: begin
        // read data holds the first breakpoint
        cmd.rd_sel = RD_LAST;
        cmd.save_prev = 1'b1;
        if (stat.x_le) begin
          cmd.loc = LOC_ZERO;
          axis_end = 1'b1;
        end else begin
          state_next = S_CHK;
        end
      end
      S_CHK: begin
        cmd.rd_sel = RD_ONE;
        cmd.k_init = 1'b1;
        if (stat.x_ge) begin
          cmd.loc = LOC_LAST;
          axis_end = 1'b1;
        end else begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (!stat.k_last && stat.x_ge) begin
          cmd.save_prev = 1'b1;
          cmd.k_inc = 1'b1;
          cmd.rd_sel = RD_KNEXT;
        end else begin
          cmd.loc = LOC_SEG;
          cnt_next = '0;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next = cnt + CNT_W'(1);
        if (cnt == CNT_W'(FRAC_BITS - 1)) axis_end = 1'b1;
      end
      S_BLEND: begin
        cnt_next = cnt + CNT_W'(1);
        // grid read, multiply and accumulate overlap by one step each
        case (cnt[2:0])
          3'd0: begin
          end
          3'd1: begin
            cmd.col_hi = 1'b1;
            cmd.mul_a = MA_GRID; cmd.mul_b = MB_INV2;
          end
          3'd2: begin
            cmd.row_hi = 1'b1;
            cmd.mul_a = MA_GRID; cmd.mul_b = MB_U2; cmd.acc = ACC_R0_LOAD;
          end
          3'd3: begin
            cmd.row_hi = 1'b1; cmd.col_hi = 1'b1;
            cmd.mul_a = MA_GRID; cmd.mul_b = MB_INV2; cmd.acc = ACC_R0_ADD;
          end
          3'd4: begin
            cmd.mul_a = MA_GRID; cmd.mul_b = MB_U2; cmd.acc = ACC_R1_LOAD;
          end
          3'd5: begin
            cmd.mul_a = MA_R0; cmd.mul_b = MB_INV1; cmd.acc = ACC_R1_ADD;
          end
          3'd6: begin
            cmd.mul_a = MA_R1; cmd.mul_b = MB_U1; cmd.acc = ACC_F_LOAD;
          end
          3'd7: begin
            cmd.acc = ACC_F_ADD;
            state_next = S_DONE;
          end
          default: begin
          end
        endcase
      end
      S_DONE: begin
        cmd.out_sel = OUT_OK;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    if (axis_end) begin
      cnt_next = '0;
      if (!axis) begin
        axis_next = 1'b1;
        state_next = S_FIRST;
      end else begin
        state_next = S_BLEND;
      end
    end
  end

  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe held longer than one cycle");
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && req_type == REQ_QUERY) |=> busy)
    else $error("query request did not start work");
  a_write_idle: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && req_type != REQ_QUERY) |=> !busy)
    else $error("write request left the block busy");
  a_done_ends: assert property (@(posedge clk) disable iff (rst) done |=> !busy)
    else $error("block still busy after result");

endmodule

// File: dv/bgi_checker.sv
// request/result monitor with grid interpolation predictor for bilinear_grid_interp
`timescale 1ns / 1ps
module bgi_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic                          busy,
  input  logic [bgi_pkg::REQ_W-1:0]     req_type,
  input  logic [3:0]                    row_index,
  input  logic [3:0]                    col_index,
  input  logic signed [31:0]            write_data,
  input  logic signed [31:0]            query_x1,
  input  logic signed [31:0]            query_x2,
  input  logic                          cfg_write,
  input  logic [0:0]                    cfg_index,
  input  logic [bgi_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          done,
  input  logic signed [31:0]            interp_value,
  input  logic [bgi_pkg::STAT_W-1:0]    status,
  output int                            mismatches,
  output int                            outstanding
);
  import bgi_pkg::*;

  typedef struct packed {
    logic signed [31:0]  value;
    logic [STAT_W-1:0]   stat;
  } interp_result_t;

  logic [CFG_W-1:0]   rows_cfg, cols_cfg;
  logic signed [31:0] row_pts [MAX_ROWS];
  logic signed [31:0] col_pts [MAX_COLS];
  logic signed [31:0] grid [MAX_ROWS*MAX_COLS];
  interp_result_t     pending_results [$];

  assign outstanding = pending_results.size();

  // segment search and fraction on one axis
  function automatic void find_segment(input bit on_cols, input int n,
                                       input logic signed [31:0] x,
                                       output int lo, output int hi,
                                       output logic [63:0] frac);
    logic signed [31:0] pts [MAX_ROWS];
    logic signed [63:0] num, den;
    int k;
    for (int i = 0; i < MAX_ROWS; i++) pts[i] = on_cols ? col_pts[i] : row_pts[i];
    frac = 0;
    if (n <= 1 || x <= pts[0]) begin
      lo = 0;
      hi = 0;
    end else if (x >= pts[n-1]) begin
      lo = n - 1;
      hi = n - 1;
    end else begin
      k = 1;
      while (k < n - 1 && pts[k] <= x) k++;
      lo = k - 1;
      hi = k;
      num = 64'(x) - 64'(pts[k-1]);
      den = 64'(pts[k]) - 64'(pts[k-1]);
      frac = (64'(num) << FRAC_BITS) / 64'(den);
    end
  endfunction

  function automatic interp_result_t interp_predict(input logic signed [31:0] x1,
                                                    input logic signed [31:0] x2);
    interp_result_t r;
    int n1, n2, i0, i1, j0, j1;
    logic [63:0] u1, u2, w [4];
    logic signed [31:0] v [4];
    logic signed [95:0] acc, wv, vv;
    n1 = (rows_cfg > MAX_ROWS) ? MAX_ROWS : int'(rows_cfg);
    n2 = (cols_cfg > MAX_COLS) ? MAX_COLS : int'(cols_cfg);
    r.value = 0;
    if (n1 == 0) begin
      r.stat = STAT_AX1_EMPTY;
      return r;
    end
    if (n2 == 0) begin
      r.stat = STAT_AX2_EMPTY;
      return r;
    end
    find_segment(1'b0, n1, x1, i0, i1, u1);
    find_segment(1'b1, n2, x2, j0, j1, u2);
    v[0] = grid[i0*MAX_COLS + j0];
    v[1] = grid[i1*MAX_COLS + j0];
    v[2] = grid[i0*MAX_COLS + j1];
    v[3] = grid[i1*MAX_COLS + j1];
    w[0] = ((64'd1 << FRAC_BITS) - u1) * ((64'd1 << FRAC_BITS) - u2);
    w[1] = u1 * ((64'd1 << FRAC_BITS) - u2);
    w[2] = ((64'd1 << FRAC_BITS) - u1) * u2;
    w[3] = u1 * u2;
    acc = 0;
    for (int i = 0; i < 4; i++) begin
      wv = {32'd0, w[i]};
      vv = {{64{v[i][31]}}, v[i]};
      acc = acc + wv * vv;
    end
    // floor of the exact sum over 2^(2*FRAC_BITS)
    acc = acc >>> (2*FRAC_BITS);
    r.value = acc[31:0];
    r.stat = STAT_OK;
    return r;
  endfunction

  always @(posedge clk) begin
    interp_result_t got, want;
    if (rst) begin
      rows_cfg <= 1;
      cols_cfg <= 1;
      pending_results.delete();
      mismatches <= 0;
    end else begin
      if (cfg_write) begin
        if (cfg_index == CFG_ROWS) rows_cfg <= cfg_data;
        else cols_cfg <= cfg_data;
      end
      if (start && !busy) begin
        case (req_type)
          REQ_AX1: row_pts[row_index] <= write_data;
          REQ_AX2: col_pts[col_index] <= write_data;
          REQ_GRID: grid[row_index*MAX_COLS + col_index] <= write_data;
          default: pending_results.push_back(interp_predict(query_x1, query_x2));
        endcase
      end
      if (done) begin
        got.value = interp_value;
        got.stat = status;
        if (pending_results.size() == 0) begin
          if (mismatches < 10) $display("unexpected result value=%0d status=%0d",
                                        got.value, got.stat);
          mismatches <= mismatches + 1;
        end else begin
          want = pending_results.pop_front();
          if (got !== want) begin
            if (mismatches < 10)
              $display("result mismatch: expected value=%0d status=%0d, got value=%0d status=%0d",
                       want.value, want.stat, got.value, got.stat);
            mismatches <= mismatches + 1;
          end
        end
      end
    end
  end
endmodule

// File: dv/tb_top.sv
// stimulus and verdict for the bilinear_grid_interp testbench
`timescale 1ns / 1ps
module tb_top;
  import bgi_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int SETTLE_CYCLES = 120;

  logic               clk, rst, start, busy, cfg_write, done;
  logic [REQ_W-1:0]   req_type;
  logic [3:0]         row_index, col_index;
  logic signed [31:0] write_data, query_x1, query_x2, interp_value;
  logic [0:0]         cfg_index;
  logic [CFG_W-1:0]   cfg_data;
  logic [STAT_W-1:0]  status;
  int                 mismatches, outstanding, gap_pct;
  int                 cycles = 0;
  logic signed [31:0] row_pts [MAX_ROWS];
  logic signed [31:0] col_pts [MAX_COLS];
  logic [CFG_W-1:0]   rows_now, cols_now;

  bilinear_grid_interp uut (.*);
  bgi_checker monitor (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic send(input logic [REQ_W-1:0] rt, input logic [3:0] ri, input logic [3:0] ci,
                      input logic signed [31:0] wd, input logic signed [31:0] x1,
                      input logic signed [31:0] x2);
    @(negedge clk);
    if ($urandom_range(99) < gap_pct) begin
      start = 0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    req_type = rt;
    row_index = ri;
    col_index = ci;
    write_data = wd;
    query_x1 = x1;
    query_x2 = x2;
    start = 1;
    // request is held until the block is free, then taken at the next rising edge
    while (busy) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    start = 0;
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_sizes(input logic [CFG_W-1:0] r, input logic [CFG_W-1:0] c);
    wait_idle();
    cfg_write = 1;
    cfg_index = CFG_ROWS;
    cfg_data = r;
    @(negedge clk);
    cfg_index = CFG_COLS;
    cfg_data = c;
    @(negedge clk);
    cfg_write = 0;
    rows_now = r;
    cols_now = c;
  endtask

  // sorted breakpoints mostly, occasionally arbitrary order with full-scale values
  task automatic load_axes(input bit scrambled);
    logic signed [31:0] p;
    for (int ax = 0; ax < 2; ax++) begin
      p = $signed($urandom_range(0, 32'h7fffffff)) - 32'sh40000000;
      for (int i = 0; i < MAX_ROWS; i++) begin
        if (scrambled) p = $urandom;
        else p = p + $signed($urandom_range(1, 1 << $urandom_range(1, 26)));
        if (ax == 0) begin
          row_pts[i] = p;
          send(REQ_AX1, 4'(i), 4'($urandom), p, $urandom, $urandom);
        end else begin
          col_pts[i] = p;
          send(REQ_AX2, 4'($urandom), 4'(i), p, $urandom, $urandom);
        end
      end
    end
  endtask

  function automatic logic signed [31:0] grid_value();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
      default: return $signed($urandom_range(0, 2000)) - 1000;
    endcase
  endfunction

  function automatic logic signed [31:0] coord(input bit on_cols);
    int n, i;
    logic signed [31:0] lo, hi;
    n = on_cols ? int'(cols_now) : int'(rows_now);
    if (n > MAX_ROWS) n = MAX_ROWS;
    if (n < 1) n = 1;
    i = $urandom_range(0, n - 1);
    lo = on_cols ? col_pts[i] : row_pts[i];
    hi = on_cols ? col_pts[n-1] : row_pts[n-1];
    case ($urandom_range(9))
      0: return $urandom;
      1: return lo;
      2: return $urandom_range(1) ? 32'sh80000000 : 32'sh7fffffff;
      default: begin
        if (hi > lo) return lo + $signed($urandom_range(0, 32'(hi - lo)));
        return lo + $signed($urandom_range(0, 65535));
      end
    endcase
  endfunction

  task automatic query_burst(input int count);
    for (int q = 0; q < count; q++) begin
      if ($urandom_range(19) == 0)
        send(REQ_GRID, 4'($urandom), 4'($urandom), grid_value(), $urandom, $urandom);
      send(REQ_QUERY, 4'($urandom), 4'($urandom), $urandom, coord(1'b0), coord(1'b1));
    end
  endtask

  initial begin
    logic [CFG_W-1:0] r, c;
    rst = 1;
    start = 0;
    cfg_write = 0;
    cfg_index = CFG_ROWS;
    cfg_data = 0;
    req_type = REQ_QUERY;
    row_index = 0;
    col_index = 0;
    write_data = 0;
    query_x1 = 0;
    query_x2 = 0;
    gap_pct = 24;
    rows_now = 1;
    cols_now = 1;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // fill every store entry so no query reads an unwritten one
    load_axes(1'b0);
    for (int i = 0; i < MAX_ROWS*MAX_COLS; i++)
      send(REQ_GRID, 4'(i / MAX_COLS), 4'(i % MAX_COLS), grid_value(), $urandom, $urandom);

    // directed: reset sizes, full grid, edges, empty axes, oversized
    send(REQ_QUERY, 0, 0, 0, 32'sh80000000, 32'sh7fffffff);
    set_sizes(16, 16);
    send(REQ_QUERY, 0, 0, 0, 32'sh80000000, 32'sh80000000);
    send(REQ_QUERY, 0, 0, 0, 32'sh7fffffff, 32'sh7fffffff);
    send(REQ_QUERY, 0, 0, 0, row_pts[0], col_pts[15]);
    send(REQ_QUERY, 0, 0, 0, row_pts[5], col_pts[7]);
    send(REQ_QUERY, 0, 0, 0, row_pts[5] + 1, col_pts[8] - 1);
    send(REQ_QUERY, 0, 0, 0, row_pts[14] + (row_pts[15] - row_pts[14]) / 2,
         col_pts[0] + (col_pts[1] - col_pts[0]) / 3);
    set_sizes(0, 5);
    send(REQ_QUERY, 0, 0, 0, 0, 0);
    set_sizes(5, 0);
    send(REQ_QUERY, 0, 0, 0, 0, 0);
    set_sizes(0, 0);
    send(REQ_QUERY, 0, 0, 0, 0, 0);
    set_sizes(31, 31);
    send(REQ_QUERY, 0, 0, 0, row_pts[9] + 3, col_pts[2] + 7);
    set_sizes(2, 1);
    send(REQ_QUERY, 0, 0, 0, row_pts[0] + 1, col_pts[0] + 1);

    // random: three idling regimes, several size settings each
    for (int ph = 0; ph < 3; ph++) begin
      gap_pct = (ph == 0) ? 24 : (ph == 1) ? 54 : 0;
      for (int s = 0; s < 4; s++) begin
        case ($urandom_range(7))
          0: r = 0;
          1: r = $urandom_range(17, 31);
          2: r = 16;
          default: r = $urandom_range(1, 16);
        endcase
        case ($urandom_range(7))
          0: c = 0;
          1: c = $urandom_range(17, 31);
          2: c = 16;
          default: c = $urandom_range(1, 16);
        endcase
        set_sizes(r, c);
        if ($urandom_range(2) == 0) load_axes($urandom_range(3) == 0);
        query_burst(10);
      end
    end

    wait_idle();
    if (mismatches == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule

// File: files.f
rtl/bgi_pkg.sv
rtl/bgi_datapath.sv
rtl/bgi_controller.sv
rtl/bilinear_grid_interp.sv
dv/bgi_checker.sv
dv/tb_top.sv
